FILE: design/swbv_pkg.sv
// ----------------------------------------------------------------------------
// swbv_pkg
// Shared constants, register codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package swbv_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned PhaseBitsDef    = 32;
  localparam int unsigned AtanEntries     = 30;
  localparam int unsigned DataW           = 32;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned CordicW         = 34;

  localparam logic signed [CordicW-1:0] CordicGain = 34'sh026DD3B6A;
  localparam logic signed [CordicW-1:0] OneQ30     = 34'sh040000000;
  localparam logic signed [63:0]        HalfQ30    = 64'sh20000000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WAVE_KX   = 3'd0,
    REG_WAVE_KY   = 3'd1,
    REG_WAVE_KZ   = 3'd2,
    REG_TIME_FREQ = 3'd3,
    REG_AMPLITUDE = 3'd4,
    REG_OFFSET    = 3'd5
  } cfg_idx_e;

  localparam logic [31:0] AtanTurns [AtanEntries] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

endpackage

FILE: design/swbv_if.sv
// ----------------------------------------------------------------------------
// swbv_if
// Valid/ready channels for face transactions and wave results.
// ----------------------------------------------------------------------------
interface swbv_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       pos_x;
  logic signed [31:0]       pos_y;
  logic signed [31:0]       pos_z;
  logic        [31:0]       sim_time;
  modport source (output valid, pos_x, pos_y, pos_z, sim_time, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, sim_time, output ready);
endinterface

interface swbv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] wave_value;
  logic               saturated;
  modport source (output valid, wave_value, saturated, input ready);
  modport sink   (input valid, wave_value, saturated, output ready);
endinterface

FILE: design/standing_wave_boundary_value_core.sv
// ----------------------------------------------------------------------------
// standing_wave_boundary_value_core
// Boundary value offset + amplitude*cos(k.x)*cos(w*t) per face, pipelined.
// ----------------------------------------------------------------------------
//   channel  dir  handshake    payload
//   in_s     in   valid/ready  pos_x, pos_y, pos_z, sim_time
//   out_s    out  valid/ready  wave_value, saturated
//   cfg      in   cfg_we_i     cfg_idx_i, cfg_data_i
//
// One transaction per cycle while out_s is not stalled; stages: two phase, CORDIC_STAGES
// (capped at 30) CORDIC, one clamp and three scaling.
// Reset clears valid bits and the configuration registers; data registers are not reset.
// A stalled output freezes every stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module standing_wave_boundary_value_core #(
  parameter int unsigned CORDIC_STAGES = swbv_pkg::CordicStagesDef,
  parameter int unsigned PHASE_BITS    = swbv_pkg::PhaseBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  swbv_in_if.sink                     in_s,
  swbv_out_if.source                  out_s,
  input  logic                        cfg_we_i,
  input  logic [swbv_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [swbv_pkg::DataW-1:0]  cfg_data_i
);

  logic [31:0] kx_q, ky_q, kz_q, tf_q, amp_q, off_q;
  logic        en_s, ph_vld_s, cs_vld_s, ct_vld_s;
  logic [31:0] ang_s_s, ang_t_s;
  logic signed [31:0] cs_s, ct_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kx_q  <= '0;
      ky_q  <= '0;
      kz_q  <= '0;
      tf_q  <= '0;
      amp_q <= '0;
      off_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        swbv_pkg::REG_WAVE_KX:   kx_q  <= cfg_data_i;
        swbv_pkg::REG_WAVE_KY:   ky_q  <= cfg_data_i;
        swbv_pkg::REG_WAVE_KZ:   kz_q  <= cfg_data_i;
        swbv_pkg::REG_TIME_FREQ: tf_q  <= cfg_data_i;
        swbv_pkg::REG_AMPLITUDE: amp_q <= cfg_data_i;
        swbv_pkg::REG_OFFSET:    off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en_s       = !(out_s.valid && !out_s.ready);
  assign in_s.ready = en_s;

  swbv_phase #(.PHASE_BITS(PHASE_BITS)) u_phase (
    .clk_i, .rst_ni,
    .en_i      (en_s),
    .valid_i   (in_s.valid),
    .pos_x_i   (in_s.pos_x),
    .pos_y_i   (in_s.pos_y),
    .pos_z_i   (in_s.pos_z),
    .sim_time_i(in_s.sim_time),
    .kx_i      (kx_q),
    .ky_i      (ky_q),
    .kz_i      (kz_q),
    .tf_i      (tf_q),
    .valid_o   (ph_vld_s),
    .ang_s_o   (ang_s_s),
    .ang_t_o   (ang_t_s)
  );

  swbv_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_s (
    .clk_i, .rst_ni,
    .en_i   (en_s),
    .valid_i(ph_vld_s),
    .ang_i  (ang_s_s),
    .valid_o(cs_vld_s),
    .cos_o  (cs_s)
  );

  swbv_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_t (
    .clk_i, .rst_ni,
    .en_i   (en_s),
    .valid_i(ph_vld_s),
    .ang_i  (ang_t_s),
    .valid_o(ct_vld_s),
    .cos_o  (ct_s)
  );

  swbv_scale u_scale (
    .clk_i, .rst_ni,
    .en_i    (en_s),
    .valid_i (cs_vld_s && ct_vld_s),
    .c1_i    (cs_s),
    .c2_i    (ct_s),
    .amp_i   (amp_q),
    .offset_i(off_q),
    .valid_o (out_s.valid),
    .value_o (out_s.wave_value),
    .sat_o   (out_s.saturated)
  );

endmodule

FILE: design/swbv_phase.sv
// ----------------------------------------------------------------------------
// swbv_phase
// Two stages: wave number and time products, then phase sum and turn angle.
// ----------------------------------------------------------------------------
module swbv_phase #(
  parameter int unsigned PHASE_BITS = swbv_pkg::PhaseBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic        [31:0] sim_time_i,
  input  logic signed [31:0] kx_i,
  input  logic signed [31:0] ky_i,
  input  logic signed [31:0] kz_i,
  input  logic        [31:0] tf_i,
  output logic               valid_o,
  output logic        [31:0] ang_s_o,
  output logic        [31:0] ang_t_o
);

  localparam int unsigned Keep = (PHASE_BITS < 32) ? PHASE_BITS : 32;
  localparam logic [31:0] AngMask = 32'(~((64'd1 << (32 - Keep)) - 64'd1));

  logic               vld1_q, vld2_q;
  logic signed [63:0] px_q, py_q, pz_q;
  logic        [63:0] pt_q;
  logic        [39:0] sum_s;
  logic        [31:0] ang_s_q, ang_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  assign sum_s = px_q[39:0] + py_q[39:0] + pz_q[39:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q    <= kx_i * pos_x_i;
      py_q    <= ky_i * pos_y_i;
      pz_q    <= kz_i * pos_z_i;
      pt_q    <= tf_i * sim_time_i;
      ang_s_q <= sum_s[39:8] & AngMask;
      ang_t_q <= pt_q[39:8] & AngMask;
    end
  end

  assign valid_o = vld2_q;
  assign ang_s_o = ang_s_q;
  assign ang_t_o = ang_t_q;

endmodule

FILE: design/swbv_cordic.sv
// ----------------------------------------------------------------------------
// swbv_cordic
// Pipelined rotation-mode CORDIC giving the cosine of a turn angle in Q2.30.
// ----------------------------------------------------------------------------
module swbv_cordic #(
  parameter int unsigned CORDIC_STAGES = swbv_pkg::CordicStagesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic        [31:0] ang_i,
  output logic               valid_o,
  output logic signed [31:0] cos_o
);

  localparam int unsigned Ns =
    (CORDIC_STAGES < swbv_pkg::AtanEntries) ? CORDIC_STAGES : swbv_pkg::AtanEntries;
  localparam int unsigned W = swbv_pkg::CordicW;

  logic signed [W-1:0] x_q [Ns+1];
  logic signed [W-1:0] y_q [Ns+1];
  logic signed [W-1:0] z_q [Ns+1];
  logic        [1:0]   quad_q [Ns+1];
  logic                vld_q [Ns+1];
  logic signed [W-1:0] r_s;
  logic signed [31:0]  cos_q;
  logic                vld_out_q;

  assign x_q[0]    = swbv_pkg::CordicGain;
  assign y_q[0]    = '0;
  assign z_q[0]    = W'(ang_i[29:0]);
  assign quad_q[0] = ang_i[31:30];
  assign vld_q[0]  = valid_i;

  for (genvar i = 0; i < Ns; i++) begin : g_stage
    logic signed [W-1:0] atan_s;
    assign atan_s = W'(swbv_pkg::AtanTurns[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quad_q[i+1] <= quad_q[i];
        if (!z_q[i][W-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_s;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_s;
        end
      end
    end
  end

  always_comb begin
    unique case (quad_q[Ns])
      2'd0:    r_s = x_q[Ns];
      2'd1:    r_s = -y_q[Ns];
      2'd2:    r_s = -x_q[Ns];
      default: r_s = y_q[Ns];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_out_q <= vld_q[Ns];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (r_s > swbv_pkg::OneQ30) begin
        cos_q <= 32'(swbv_pkg::OneQ30);
      end else if (r_s < -swbv_pkg::OneQ30) begin
        cos_q <= 32'(-swbv_pkg::OneQ30);
      end else begin
        cos_q <= 32'(r_s);
      end
    end
  end

  assign valid_o = vld_out_q;
  assign cos_o   = cos_q;

endmodule

FILE: design/swbv_scale.sv
// ----------------------------------------------------------------------------
// swbv_scale
// Cosine product, amplitude scaling, offset and saturation over three stages.
// ----------------------------------------------------------------------------
module swbv_scale (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] c1_i,
  input  logic signed [31:0] c2_i,
  input  logic signed [31:0] amp_i,
  input  logic signed [31:0] offset_i,
  output logic               valid_o,
  output logic signed [31:0] value_o,
  output logic               sat_o
);

  localparam logic signed [63:0] MaxV = 64'sh7FFFFFFF;
  localparam logic signed [63:0] MinV = -64'sh80000000;

  logic               vld1_q, vld2_q, vld3_q;
  logic signed [63:0] p_q, m_q, c_s, v_s, rnd_s;
  logic signed [31:0] val_q;
  logic               sat_q;

  assign c_s   = (p_q + swbv_pkg::HalfQ30) >>> 30;
  assign rnd_s = (m_q + swbv_pkg::HalfQ30) >>> 30;
  assign v_s   = rnd_s + 64'(offset_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= c1_i * c2_i;
      m_q <= amp_i * 32'(c_s);
      if (v_s > MaxV) begin
        val_q <= 32'(MaxV);
        sat_q <= 1'b1;
      end else if (v_s < MinV) begin
        val_q <= 32'(MinV);
        sat_q <= 1'b1;
      end else begin
        val_q <= 32'(v_s);
        sat_q <= 1'b0;
      end
    end
  end

  assign valid_o = vld3_q;
  assign value_o = val_q;
  assign sat_o   = sat_q;

endmodule

FILE: design/swbv_checker.sv
// ----------------------------------------------------------------------------
// swbv_checker
// Port-level checks of the core, attached by bind.
// ----------------------------------------------------------------------------
module swbv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] wave_value_i,
  input logic        saturated_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_val_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(wave_value_i) && $stable(saturated_i))
    else $error("result changed while stalled");

  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i |->
      (wave_value_i == 32'h7FFFFFFF) || (wave_value_i == 32'h80000000))
    else $error("saturated result off the rail");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == !(out_valid_i && !out_ready_i))
    else $error("input ready does not follow output stall");

endmodule

bind standing_wave_boundary_value_core swbv_checker u_swbv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_s.ready),
  .out_valid_i (out_s.valid),
  .out_ready_i (out_s.ready),
  .wave_value_i(out_s.wave_value),
  .saturated_i (out_s.saturated)
);
